### rtl/core/char_lcd_text_wrap_nibble_writer_assert.svh
// assertion macros for the checker
`ifndef CHAR_LCD_TEXT_WRAP_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_TEXT_WRAP_NIBBLE_WRITER_ASSERT_SVH

// same-cycle implication
`define LCDW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCDW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lcdw_pkg.sv
`default_nettype none
package lcdw_pkg;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW = $clog2(QDEPTH);

	localparam logic [7:0] NEWLINE = 8'h0A;
	localparam logic [7:0] SET_ADDR = 8'h80;
	localparam logic [7:0] NIBBLE = 8'hF0;

	localparam logic FUNC_TEXT = 1'b0;
	localparam logic FUNC_RAW = 1'b1;

	typedef enum logic [2:0] {
		REG_LAST_ROW,
		REG_COLUMNS,
		REG_ENABLE_MASK,
		REG_BACKLIGHT_MASK,
		REG_CHAR_SELECT_MASK
	} reg_idx_t;

	typedef enum logic [1:0] {
		STB_SETUP,
		STB_RISE,
		STB_FALL
	} strobe_t;

	typedef struct packed {
		logic [7:0] code;
		logic       func;
		logic       first_of_string;
	} item_t;

	typedef struct packed {
		logic [7:0] expander_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] last_row;
		logic [5:0] columns;
		logic [7:0] enable_mask;
		logic [7:0] backlight_mask;
		logic [7:0] char_select_mask;
	} cfg_t;

	// one or two display bytes for the back end
	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic       is_char;
		logic       has_addr;
		logic [7:0] addr;
	} cmd_t;

	function automatic logic [7:0] row_addr(input logic [1:0] row);
		logic [7:0] base;
		case (row)
			2'd0: base = 8'h00;
			2'd1: base = 8'h40;
			2'd2: base = 8'h14;
			2'd3: base = 8'h54;
			default: base = 8'h00;
		endcase
		return SET_ADDR | base;
	endfunction
endpackage
`default_nettype wire

### rtl/core/lcdw_queue.sv
`default_nettype none
module lcdw_queue import lcdw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      full,
	output logic      empty
);
	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/lcdw_front.sv
`default_nettype none
module lcdw_front import lcdw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire logic  accept,
	output cmd_t       cmd,
	output logic       cmd_push
);
	logic [1:0] row_q;
	logic [5:0] col_q;
	logic       stopped_q;
	logic [1:0] row;
	logic [5:0] col;
	logic       stop;
	logic [1:0] row_n;
	logic [5:0] col_n;
	logic       stop_n;
	logic [5:0] col_inc;
	logic       at_last;
	logic       emit;

	always_comb begin
		row = item.first_of_string ? 2'd0 : row_q;
		col = item.first_of_string ? 6'd0 : col_q;
		stop = item.first_of_string ? 1'b0 : stopped_q;
		col_inc = col + 6'd1;
		at_last = (row >= cfg.last_row);
		row_n = row;
		col_n = col;
		stop_n = stop;
		emit = 1'b0;
		cmd = '0;
		if (item.func == FUNC_RAW) begin
			emit = 1'b1;
			cmd.has_data = 1'b1;
			cmd.data = item.code;
		end else if (!stop) begin
			if (item.code == NEWLINE) begin
				col_n = 6'd0;
				if (at_last) begin
					stop_n = 1'b1;
				end else begin
					row_n = row + 2'd1;
					emit = 1'b1;
					cmd.has_addr = 1'b1;
					cmd.addr = row_addr(row + 2'd1);
				end
			end else begin
				emit = 1'b1;
				cmd.has_data = 1'b1;
				cmd.data = item.code;
				cmd.is_char = 1'b1;
				if (col_inc >= cfg.columns) begin
					col_n = 6'd0;
					if (at_last) begin
						stop_n = 1'b1;
					end else begin
						row_n = row + 2'd1;
						cmd.has_addr = 1'b1;
						cmd.addr = row_addr(row + 2'd1);
					end
				end else begin
					col_n = col_inc;
				end
			end
		end
	end

	assign cmd_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			row_q <= row_n;
			col_q <= col_n;
			stopped_q <= stop_n;
		end
	end
endmodule
`default_nettype wire

### rtl/core/lcdw_back.sv
`default_nettype none
module lcdw_back import lcdw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire cmd_t cmd,
	input  wire logic cmd_valid,
	output logic      cmd_pop,
	output result_t   result,
	output logic      empty,
	input  wire logic pop
);
	strobe_t    stb_q;
	strobe_t    stb_n;
	logic       low_q;
	logic       low_n;
	logic       addr_q;
	logic       addr_n;
	logic       out_valid_q;
	result_t    result_q;
	logic       advance;
	logic       sel_addr;
	logic [7:0] disp_byte;
	logic [7:0] nib;
	logic [7:0] base;
	logic [7:0] wbyte;
	logic       last_w;

	assign advance = cmd_valid && (!out_valid_q || pop);

	// expander write for the current position
	always_comb begin
		sel_addr = !cmd.has_data || addr_q;
		disp_byte = sel_addr ? cmd.addr : cmd.data;
		nib = low_q ? {disp_byte[3:0], 4'h0} : (disp_byte & NIBBLE);
		base = nib | cfg.backlight_mask
			| ((!sel_addr && cmd.is_char) ? cfg.char_select_mask : 8'h00);
		case (stb_q)
			STB_SETUP: wbyte = base;
			STB_RISE:  wbyte = base | cfg.enable_mask;
			STB_FALL:  wbyte = base & ~cfg.enable_mask;
			default:   wbyte = base;
		endcase
		last_w = (stb_q == STB_FALL) && low_q && (sel_addr || !cmd.has_addr);
		cmd_pop = advance && last_w;
	end

	always_comb begin
		stb_n = stb_q;
		low_n = low_q;
		addr_n = addr_q;
		if (advance) begin
			case (stb_q)
				STB_SETUP: stb_n = STB_RISE;
				STB_RISE:  stb_n = STB_FALL;
				STB_FALL:  stb_n = STB_SETUP;
				default:   stb_n = STB_SETUP;
			endcase
			if (stb_q == STB_FALL) begin
				if (!low_q) begin
					low_n = 1'b1;
				end else begin
					low_n = 1'b0;
					addr_n = !last_w;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stb_q <= STB_SETUP;
			low_q <= 1'b0;
			addr_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			stb_q <= stb_n;
			low_q <= low_n;
			addr_q <= addr_n;
			out_valid_q <= advance || (out_valid_q && !pop);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= '{expander_byte: wbyte, last: last_w};
		end
	end

	assign result = result_q;
	assign empty = !out_valid_q;
endmodule
`default_nettype wire

### rtl/core/char_lcd_text_wrap_nibble_writer.sv
// Text-to-expander writer for a character display in four-bit mode. Each accepted item
// becomes six expander writes per display byte: a text character gives six, or twelve
// when it fills the row and a set-address command follows; a newline gives six (none on
// the last row); a raw command gives six; text after the rows run out gives none until an
// item with first_of_string. Results leave at one write per cycle while pop takes each one,
// set by the single nibble sequencer in the back end. Input items are taken every cycle
// while the four-entry command queue between the cursor logic and the sequencer has room.
// The user must write configuration registers through the cfg channel only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module char_lcd_text_wrap_nibble_writer import lcdw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire item_t      item,
	input  wire logic       push,
	output logic            full,
	output result_t         result,
	output logic            empty,
	input  wire logic       pop,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic front_push;
	logic q_empty;
	logic q_pop;
	logic accept;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.last_row <= 2'd1;
			cfg_q.columns <= 6'd16;
			cfg_q.enable_mask <= 8'h04;
			cfg_q.backlight_mask <= 8'h08;
			cfg_q.char_select_mask <= 8'h01;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LAST_ROW:         cfg_q.last_row <= cfg_data[1:0];
				REG_COLUMNS:          cfg_q.columns <= cfg_data[5:0];
				REG_ENABLE_MASK:      cfg_q.enable_mask <= cfg_data;
				REG_BACKLIGHT_MASK:   cfg_q.backlight_mask <= cfg_data;
				REG_CHAR_SELECT_MASK: cfg_q.char_select_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	lcdw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.item     (item),
		.accept   (accept),
		.cmd      (front_cmd),
		.cmd_push (front_push)
	);

	lcdw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wdata  (front_cmd),
		.pop    (q_pop),
		.rdata  (head_cmd),
		.full   (full),
		.empty  (q_empty)
	);

	lcdw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (head_cmd),
		.cmd_valid (!q_empty),
		.cmd_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);
endmodule
`default_nettype wire

### rtl/core/lcdw_checker.sv
`default_nettype none
`include "char_lcd_text_wrap_nibble_writer_assert.svh"
module lcdw_checker import lcdw_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire item_t      item,
	input wire logic       push,
	input wire logic       full,
	input wire result_t    result,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [7:0] cfg_data
);
	// a waiting result holds until taken
	`LCDW_ASSERT_NXT(a_result_hold, !empty && !pop, !empty && $stable(result), "result changed while waiting")
	// the writes of one item follow without a gap
	`LCDW_ASSERT_NXT(a_no_gap, pop && !empty && !result.last, !empty, "gap inside an item's writes")
	// a full queue always has a result on show
	`LCDW_ASSERT_IMP(a_full_has_out, full, !empty, "queue full with no result shown")
	// configuration is never back-pressured
	`LCDW_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")
endmodule

bind char_lcd_text_wrap_nibble_writer lcdw_checker u_chk (.*);
`default_nettype wire
